// File: design/bua_pkg.sv
`timescale 1ns / 1ps

package bua_pkg;

   // Field widths
   localparam int NUM_W    = 16;
   localparam int BASE_W   = 15;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // Bitmap word geometry: 32 units per word, 32 words per summary word
   localparam int WORD_W   = 32;
   localparam int WORD_LOG = 5;

   // Request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL         = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_UNITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_OFFSET = 2'd1;

   // Result of the find-first-zero unit
   typedef struct packed {
      logic                none;
      logic [WORD_LOG-1:0] pos;
   } ffz_type;

endpackage

// File: design/bua_if.sv
`timescale 1ns / 1ps

interface bua_req_if;
   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [bua_pkg::NUM_W-1:0] unit_number;

   modport source (output valid, output op, output unit_number, input ready);
   modport sink (input valid, input op, input unit_number, output ready);
endinterface

interface bua_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bua_pkg::STATUS_W-1:0] status;
   logic [bua_pkg::NUM_W-1:0]    granted_unit;
   logic [bua_pkg::NUM_W-1:0]    free_count;

   modport source (output valid, output status, output granted_unit, output free_count,
                   input ready);
   modport sink (input valid, input status, input granted_unit, input free_count,
                 output ready);
endinterface

interface bua_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bua_pkg::CSR_IDX_W-1:0]  index;
   logic [bua_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/bua_ram.sv
`timescale 1ns / 1ps

module bua_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/bua_ffz.sv
`timescale 1ns / 1ps

module bua_ffz (
   input  logic [bua_pkg::WORD_W-1:0] word,
   output bua_pkg::ffz_type           res
);

   always_comb begin
      res.none = &word;
      res.pos  = '0;
      // scan downward so the lowest clear bit wins
      for (int i = bua_pkg::WORD_W - 1; i >= 0; i--) begin
         if (!word[i]) begin
            res.pos = bua_pkg::WORD_LOG'(i);
         end
      end
   end

endmodule

// File: design/bitmap_unit_allocator.sv
// First-fit unit allocator over a used/free bitmap of UNITS units.
// req_ch carries op (0 allocate, 1 free) and unit_number; rsp_ch returns one
// response per request with status, granted_unit and free_count. csr_ch
// writes total_units (index 0) and base_offset (index 1); other indexes are
// dropped. csr_ch is always ready; write it only while no request is open.
// The bitmap lives in a RAM of 32-bit words; a second RAM keeps one "word
// full" bit per bitmap word. A single find-first-zero unit serves both
// levels under a small sequencer, and a hint register points at the lowest
// summary word that may still hold a free word.
// Path from request to response: free passes S_FREE and S_DONE; allocate
// passes S_SCAN, S_ALLOC and S_DONE, repeating S_SCAN for every completely
// used 1024-unit group that the hint has to step over (usually none). One
// request is in flight at a time; the next request is taken while the
// previous response waits in the output register.
// Reset clears the configuration to total_units 32768 and base_offset 0 and
// frees every unit at once: fill counters mark the RAM words never written,
// which read as all free, so no clearing pass is needed.
// When the receiver stalls, the response holds in the output register and a
// finished request waits before loading it; nothing is dropped.
`timescale 1ns / 1ps

module bitmap_unit_allocator #(
   parameter int UNITS = 32768
) (
   input  logic             clock,
   input  logic             reset,
   bua_req_if.sink          req_ch,
   bua_rsp_if.source        rsp_ch,
   bua_csr_if.sink          csr_ch
);

   localparam int WL        = bua_pkg::WORD_LOG;
   localparam int WW        = bua_pkg::WORD_W;
   localparam int WORDS     = (UNITS + WW - 1) / WW;
   localparam int SUM_WORDS = (WORDS + WW - 1) / WW;
   localparam int HW        = $clog2(SUM_WORDS + 1);
   localparam int IW        = HW + 2 * WL;
   localparam int WIW       = IW - WL;
   localparam int MAP_AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int SUM_AW    = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
   localparam int MFW       = $clog2(WORDS + 1);
   localparam int CW        = (IW > 16) ? IW : 17;
   localparam int NW        = bua_pkg::NUM_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_ALLOC = 3'd2;
   localparam logic [2:0] S_FREE  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   // Control state
   logic [2:0]              state_ff, state_in;
   logic [NW-1:0]           total_units_ff, total_units_in;
   logic [bua_pkg::BASE_W-1:0] base_offset_ff, base_offset_in;
   logic [NW-1:0]           used_count_ff, used_count_in;
   logic [MFW-1:0]          map_fill_ff, map_fill_in;
   logic [HW-1:0]           sum_fill_ff, sum_fill_in;
   logic [HW-1:0]           hint_ff, hint_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic [IW-1:0]           idx_ff, idx_in;
   logic                    bad_ff, bad_in;
   logic [WIW-1:0]          w_ff, w_in;
   logic [WW-1:0]           sum_word_ff, sum_word_in;
   logic [WL-1:0]           sum_pos_ff, sum_pos_in;
   logic [1:0]              res_status_ff, res_status_in;
   logic [NW-1:0]           res_granted_ff, res_granted_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [NW-1:0]           rsp_granted_ff, rsp_granted_in;
   logic [NW-1:0]           rsp_free_ff, rsp_free_in;

   // RAM ports
   logic                    map_we, sum_we;
   logic [WIW-1:0]          map_waddr, map_raddr;
   logic [HW-1:0]           sum_waddr, sum_raddr;
   logic [WW-1:0]           map_wdata, sum_wdata, map_rdata, sum_rdata;

   // Shared find-first-zero
   logic [WW-1:0]           ffz_word;
   bua_pkg::ffz_type        ffz_res;

   // Datapath helpers
   logic [CW-1:0]           units_cw, total_cw, mtotal_cw;
   logic [NW-1:0]           mtotal;
   logic [NW-1:0]           diff16;
   logic [CW-1:0]           diff_cw;
   logic [IW-1:0]           idx_now;
   logic                    bad_now;
   logic [WIW-1:0]          fw_now, fw_ff, scan_w;
   logic [HW-1:0]           fs_now, fs_ff, hint_next;
   logic [IW-1:0]           scan_base, unit_idx;
   logic [CW-1:0]           granted_cw;
   logic [WW-1:0]           map_word, sum_word_scan, sum_word_free;
   logic [WW-1:0]           map_set, sum_bit_scan, free_bit, sum_bit_free;
   logic                    req_fire, slot_free;

   bua_ram #(.WIDTH(WW), .DEPTH(WORDS)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr[MAP_AW-1:0]),
      .wr_data (map_wdata),
      .rd_addr (map_raddr[MAP_AW-1:0]),
      .rd_data (map_rdata)
   );

   bua_ram #(.WIDTH(WW), .DEPTH(SUM_WORDS)) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (sum_waddr[SUM_AW-1:0]),
      .wr_data (sum_wdata),
      .rd_addr (sum_raddr[SUM_AW-1:0]),
      .rd_data (sum_rdata)
   );

   bua_ffz u_ffz (
      .word (ffz_word),
      .res  (ffz_res)
   );

   assign req_ch.ready  = (state_ff == S_IDLE);
   assign csr_ch.ready  = 1'b1;
   assign req_fire      = req_ch.valid && req_ch.ready;
   assign slot_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.granted_unit = rsp_granted_ff;
   assign rsp_ch.free_count   = rsp_free_ff;

   // Managed total: the smaller of total_units and UNITS, always below 2^16
   assign units_cw  = CW'(UNITS);
   assign total_cw  = CW'(total_units_ff);
   assign mtotal_cw = (total_cw > units_cw) ? units_cw : total_cw;
   assign mtotal    = mtotal_cw[NW-1:0];

   // Free request decode straight from the request port
   assign diff16  = req_ch.unit_number - NW'(base_offset_ff);
   assign diff_cw = CW'(diff16);
   assign bad_now = (req_ch.unit_number < NW'(base_offset_ff)) || (diff_cw >= mtotal_cw);
   assign idx_now = diff_cw[IW-1:0];
   assign fw_now  = idx_now[IW-1:WL];
   assign fs_now  = idx_now[IW-1:2*WL];
   assign fw_ff   = idx_ff[IW-1:WL];
   assign fs_ff   = idx_ff[IW-1:2*WL];

   assign hint_next = hint_ff + 1'b1;
   assign scan_w    = {hint_ff, ffz_res.pos};
   assign scan_base = {scan_w, WL'(0)};
   assign unit_idx  = {w_ff, ffz_res.pos};
   assign granted_cw = CW'(unit_idx) + CW'(base_offset_ff);

   // Words past the fill counters were never written and read as all free
   assign sum_word_scan = (hint_ff < sum_fill_ff) ? sum_rdata : '0;
   assign sum_word_free = (fs_ff < sum_fill_ff) ? sum_rdata : '0;
   assign map_word = (state_ff == S_FREE) ?
                     ((fw_ff < WIW'(map_fill_ff)) ? map_rdata : '0) :
                     ((w_ff < WIW'(map_fill_ff)) ? map_rdata : '0);

   assign ffz_word     = (state_ff == S_SCAN) ? sum_word_scan : map_word;
   assign map_set      = map_word | (WW'(1) << ffz_res.pos);
   assign sum_bit_scan = WW'(1) << sum_pos_ff;
   assign free_bit     = WW'(1) << idx_ff[WL-1:0];
   assign sum_bit_free = WW'(1) << fw_ff[WL-1:0];

   always_comb begin
      state_in       = state_ff;
      total_units_in = total_units_ff;
      base_offset_in = base_offset_ff;
      used_count_in  = used_count_ff;
      map_fill_in    = map_fill_ff;
      sum_fill_in    = sum_fill_ff;
      hint_in        = hint_ff;
      idx_in         = idx_ff;
      bad_in         = bad_ff;
      w_in           = w_ff;
      sum_word_in    = sum_word_ff;
      sum_pos_in     = sum_pos_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_free_in    = rsp_free_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;

      map_we    = 1'b0;
      map_waddr = w_ff;
      map_wdata = map_set;
      sum_we    = 1'b0;
      sum_waddr = hint_ff;
      sum_wdata = sum_word_ff | sum_bit_scan;
      map_raddr = fw_now;
      sum_raddr = (req_ch.op == bua_pkg::OP_FREE) ? fs_now : hint_ff;

      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            bua_pkg::CSR_TOTAL_UNITS: total_units_in = csr_ch.data;
            bua_pkg::CSR_BASE_OFFSET: base_offset_in = csr_ch.data[bua_pkg::BASE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               idx_in = idx_now;
               bad_in = bad_now;
               state_in = (req_ch.op == bua_pkg::OP_FREE) ? S_FREE : S_SCAN;
            end
         end

         S_SCAN: begin
            // Read ahead: next summary word and the bitmap word picked now
            sum_raddr   = hint_next;
            map_raddr   = scan_w;
            w_in        = scan_w;
            sum_word_in = sum_word_scan;
            sum_pos_in  = ffz_res.pos;
            if (hint_ff == HW'(SUM_WORDS)) begin
               res_status_in  = bua_pkg::ST_FULL;
               res_granted_in = '0;
               state_in       = S_DONE;
            end else if (ffz_res.none) begin
               // whole group used: step the hint
               hint_in = hint_next;
            end else if (CW'(scan_base) >= mtotal_cw) begin
               res_status_in  = bua_pkg::ST_FULL;
               res_granted_in = '0;
               state_in       = S_DONE;
            end else begin
               state_in = S_ALLOC;
            end
         end

         S_ALLOC: begin
            state_in = S_DONE;
            if (ffz_res.none || (CW'(unit_idx) >= mtotal_cw)) begin
               res_status_in  = bua_pkg::ST_FULL;
               res_granted_in = '0;
            end else begin
               res_status_in  = bua_pkg::ST_OK;
               res_granted_in = granted_cw[NW-1:0];
               used_count_in  = used_count_ff + 1'b1;
               map_we         = 1'b1;
               if (w_ff == WIW'(map_fill_ff)) begin
                  map_fill_in = map_fill_ff + 1'b1;
               end
               if (&map_set) begin
                  sum_we = 1'b1;
                  if (hint_ff == sum_fill_ff) begin
                     sum_fill_in = sum_fill_ff + 1'b1;
                  end
               end
            end
         end

         S_FREE: begin
            state_in       = S_DONE;
            res_granted_in = '0;
            map_waddr      = fw_ff;
            map_wdata      = map_word & ~free_bit;
            sum_waddr      = fs_ff;
            sum_wdata      = sum_word_free & ~sum_bit_free;
            priority if (bad_ff) begin
               res_status_in = bua_pkg::ST_RANGE;
            end else if ((map_word & free_bit) == '0) begin
               res_status_in = bua_pkg::ST_ALREADY_FREE;
            end else begin
               res_status_in = bua_pkg::ST_OK;
               map_we        = 1'b1;
               if (used_count_ff != '0) begin
                  used_count_in = used_count_ff - 1'b1;
               end
               if (fw_ff == WIW'(map_fill_ff)) begin
                  map_fill_in = map_fill_ff + 1'b1;
               end
               // word leaves the full state: clear its summary bit, pull the hint down
               if (&map_word) begin
                  sum_we = 1'b1;
                  if (fs_ff == sum_fill_ff) begin
                     sum_fill_in = sum_fill_ff + 1'b1;
                  end
                  if (fs_ff < hint_ff) begin
                     hint_in = fs_ff;
                  end
               end
            end
         end

         S_DONE: begin
            // hold until the output register frees up
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_granted_in = res_granted_ff;
               rsp_free_in    = (mtotal > used_count_ff) ? (mtotal - used_count_ff) : '0;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         total_units_ff <= NW'(32768);
         base_offset_ff <= '0;
         used_count_ff  <= '0;
         map_fill_ff    <= '0;
         sum_fill_ff    <= '0;
         hint_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         total_units_ff <= total_units_in;
         base_offset_ff <= base_offset_in;
         used_count_ff  <= used_count_in;
         map_fill_ff    <= map_fill_in;
         sum_fill_ff    <= sum_fill_in;
         hint_ff        <= hint_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      bad_ff         <= bad_in;
      w_ff           <= w_in;
      sum_word_ff    <= sum_word_in;
      sum_pos_ff     <= sum_pos_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_free_ff    <= rsp_free_in;
   end

   // Every summary word below the hint has been written as all full
   a_hint_in_fill: assert property (@(posedge clock) disable iff (reset)
      hint_ff <= sum_fill_ff)
      else $error("hint points past the written summary words");

   a_map_fill_bound: assert property (@(posedge clock) disable iff (reset)
      map_fill_ff <= MFW'(WORDS))
      else $error("bitmap fill counter ran past the bitmap depth");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the done step");

   a_used_step: assert property (@(posedge clock) disable iff (reset)
      (used_count_ff != $past(used_count_ff)) |->
         ($past(state_ff == S_ALLOC) || $past(state_ff == S_FREE)))
      else $error("used count moved outside an allocate or free step");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int UNIT_COUNT = 32768;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int SETTLE_CYCLES = 20;

   // Register indexes past the list: writes to them are dropped
   localparam logic [bua_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [bua_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic [bua_pkg::STATUS_W-1:0] status;
      logic [bua_pkg::NUM_W-1:0]    granted;
      logic [bua_pkg::NUM_W-1:0]    free_count;
   } alloc_result_type;

   class unit_ledger;
      bit               used_map[UNIT_COUNT];
      int unsigned      used_count;
      int unsigned      total_units;
      int unsigned      base_offset;
      int unsigned      errors;
      alloc_result_type pending_results[$];

      function new();
         used_count  = 0;
         total_units = 32768;
         base_offset = 0;
         errors      = 0;
      endfunction

      function void report(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         errors++;
      endfunction

      function int unsigned managed_total();
         return (total_units > UNIT_COUNT) ? UNIT_COUNT : total_units;
      endfunction

      function void write_reg(logic [bua_pkg::CSR_IDX_W-1:0] idx,
                              logic [bua_pkg::CSR_DATA_W-1:0] data);
         if (idx == bua_pkg::CSR_TOTAL_UNITS) begin
            total_units = data;
         end else if (idx == bua_pkg::CSR_BASE_OFFSET) begin
            base_offset = data[bua_pkg::BASE_W-1:0];
         end
      endfunction

      function void note_request(logic op, logic [bua_pkg::NUM_W-1:0] num);
         int unsigned      t;
         int unsigned      idx;
         alloc_result_type r;
         t = managed_total();
         r.granted = '0;
         if (op == bua_pkg::OP_ALLOC) begin
            r.status = bua_pkg::ST_FULL;
            for (int unsigned i = 0; i < t; i++) begin
               if (!used_map[i]) begin
                  used_map[i] = 1'b1;
                  used_count  = (used_count + 1) & 16'hFFFF;
                  r.granted   = bua_pkg::NUM_W'(i + base_offset);
                  r.status    = bua_pkg::ST_OK;
                  break;
               end
            end
         end else if (num < base_offset) begin
            r.status = bua_pkg::ST_RANGE;
         end else begin
            idx = num - base_offset;
            if (idx >= t) begin
               r.status = bua_pkg::ST_RANGE;
            end else if (!used_map[idx]) begin
               r.status = bua_pkg::ST_ALREADY_FREE;
            end else begin
               used_map[idx] = 1'b0;
               if (used_count > 0) used_count--;
               r.status = bua_pkg::ST_OK;
            end
         end
         r.free_count = (t > used_count) ? bua_pkg::NUM_W'(t - used_count) : '0;
         pending_results.push_back(r);
      endfunction

      function void check_response(logic [bua_pkg::STATUS_W-1:0] status,
                                   logic [bua_pkg::NUM_W-1:0] granted,
                                   logic [bua_pkg::NUM_W-1:0] free_count);
         alloc_result_type e;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected response status=%0d granted=%0d free=%0d",
                             status, granted, free_count));
            return;
         end
         e = pending_results.pop_front();
         if (status !== e.status)
            report($sformatf("status %0d, expected %0d", status, e.status));
         if (granted !== e.granted)
            report($sformatf("granted_unit %0d, expected %0d", granted, e.granted));
         if (free_count !== e.free_count)
            report($sformatf("free_count %0d, expected %0d", free_count, e.free_count));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   hold_off = 0;
   bit   idle_on  = 1'b1;
   unit_ledger ledger = new();

   bua_req_if req_ch ();
   bua_rsp_if rsp_ch ();
   bua_csr_if csr_ch ();

   bitmap_unit_allocator #(.UNITS(UNIT_COUNT)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("bitmap_unit_allocator verification failed");
      $finish;
   end

   // Response side: random stall bursts, plus a long hold-off on request
   initial begin
      int  stall_left;
      bit  rdy;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            hold_off--;
            rdy = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            rdy = 1'b0;
         end else begin
            rdy = !reset;
         end
         rsp_ch.ready = rdy;
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready)
            ledger.check_response(rsp_ch.status, rsp_ch.granted_unit, rsp_ch.free_count);
      end
   end

   task automatic send_request(input logic op, input logic [bua_pkg::NUM_W-1:0] num);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 5)) begin
            @(negedge clock);
            req_ch.valid = 1'b0;
         end
      end
      @(negedge clock);
      req_ch.valid       = 1'b1;
      req_ch.op          = op;
      req_ch.unit_number = num;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      ledger.note_request(op, num);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (ledger.pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [bua_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bua_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      ledger.write_reg(idx, data);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic run_phase(input int unsigned total, input int unsigned base, input int items,
                            input int alloc_pct, input bit idle, input int pause_at,
                            input int hold_at);
      int unsigned t;
      int unsigned span;
      int          pick;
      logic [bua_pkg::NUM_W-1:0] num;
      wait_idle();
      csr_write(bua_pkg::CSR_TOTAL_UNITS, bua_pkg::CSR_DATA_W'(total));
      csr_write(bua_pkg::CSR_BASE_OFFSET, bua_pkg::CSR_DATA_W'(base));
      idle_on = idle;
      t = ledger.managed_total();
      span = (t > 64) ? 64 : t;
      for (int n = 0; n < items; n++) begin
         if (n == pause_at) begin
            @(negedge clock);
            req_ch.valid = 1'b0;
            while (ledger.pending_results.size() != 0) @(posedge clock);
         end
         if (n == hold_at) hold_off = HOLD_OFF_CYCLES;
         if ($urandom_range(0, 99) < alloc_pct) begin
            send_request(bua_pkg::OP_ALLOC, bua_pkg::NUM_W'($urandom));
         end else begin
            pick = $urandom_range(0, 99);
            // mostly near the managed range so frees hit used units
            if (pick < 70)
               num = bua_pkg::NUM_W'(ledger.base_offset + $urandom_range(0, span));
            else if (pick < 80)
               num = bua_pkg::NUM_W'(ledger.base_offset - $urandom_range(1, 3));
            else
               num = bua_pkg::NUM_W'($urandom);
            send_request(bua_pkg::OP_FREE, num);
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.op          = bua_pkg::OP_ALLOC;
      req_ch.unit_number = '0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = bua_pkg::CSR_TOTAL_UNITS;
      csr_ch.data        = '0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // reset settings: lowest units, double free, range edges
      send_request(bua_pkg::OP_ALLOC, 16'h0000);
      send_request(bua_pkg::OP_ALLOC, 16'hFFFF);
      send_request(bua_pkg::OP_FREE, 16'd0);
      send_request(bua_pkg::OP_FREE, 16'd0);
      send_request(bua_pkg::OP_FREE, 16'd32768);
      send_request(bua_pkg::OP_FREE, 16'hFFFF);

      // tiny pool with a base: run full, free below base and past total
      wait_idle();
      csr_write(bua_pkg::CSR_TOTAL_UNITS, 16'd3);
      csr_write(bua_pkg::CSR_BASE_OFFSET, 16'd100);
      send_request(bua_pkg::OP_ALLOC, 16'd0);
      send_request(bua_pkg::OP_ALLOC, 16'd0);
      send_request(bua_pkg::OP_ALLOC, 16'd0);
      send_request(bua_pkg::OP_FREE, 16'd99);
      send_request(bua_pkg::OP_FREE, 16'd103);
      send_request(bua_pkg::OP_FREE, 16'd101);
      send_request(bua_pkg::OP_ALLOC, 16'd0);

      // shrink the total below the used units
      wait_idle();
      csr_write(bua_pkg::CSR_TOTAL_UNITS, 16'd1);
      send_request(bua_pkg::OP_FREE, 16'd102);
      send_request(bua_pkg::OP_ALLOC, 16'd0);
      send_request(bua_pkg::OP_FREE, 16'd100);

      // dropped indexes, total above the unit count, widest base
      wait_idle();
      csr_write(CSR_SPARE_A, 16'hFFFF);
      csr_write(CSR_SPARE_B, 16'h1234);
      csr_write(bua_pkg::CSR_TOTAL_UNITS, 16'hFFFF);
      csr_write(bua_pkg::CSR_BASE_OFFSET, 16'hFFFF);
      send_request(bua_pkg::OP_ALLOC, 16'd0);
      send_request(bua_pkg::OP_FREE, 16'hFFFF);
      send_request(bua_pkg::OP_FREE, 16'd32768);

      run_phase(16,    0,     120, 55, 1'b1, -1, -1);
      run_phase(40,    12345, 120, 70, 1'b1, -1, -1);
      run_phase(65535, 32767, 100, 60, 1'b1, 50, -1);
      run_phase(1,     5,     60,  50, 1'b0, -1, -1);
      run_phase(0,     0,     40,  50, 1'b1, -1, -1);
      run_phase(300,   777,   250, 80, 1'b1, -1, 50);
      run_phase(20,    777,   100, 40, 1'b1, -1, -1);
      run_phase(32768, 1,     160, 50, 1'b0, -1, -1);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ledger.errors == 0) begin
         $display("bitmap_unit_allocator verification clean");
      end else begin
         $display("bitmap_unit_allocator verification failed");
      end
      $finish;
   end

endmodule

// File: bitmap_unit_allocator.f
design/bua_pkg.sv
design/bua_if.sv
design/bua_ram.sv
design/bua_ffz.sv
design/bitmap_unit_allocator.sv
dv/tb.sv
